>>> hw/rtl/brainfuck_step_engine_core_defines.svh
// ----------------------------------------------------------------------------
// Brainfuck step engine assertion macros
// Concurrent assertion helpers used by the controller RTL; they expand to nothing
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BRAINFUCK_STEP_ENGINE_CORE_DEFINES_SVH
`define BRAINFUCK_STEP_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTH

`define BFSE_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define BFSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define BFSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BFSE_ASSERT(label, expr, msg)

`define BFSE_ASSERT_IMP(label, ante, cons, msg)

`define BFSE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> hw/rtl/bfse_pkg.sv
// ----------------------------------------------------------------------------
// Brainfuck step engine package
// Sizes, instruction symbols, status codes, transfer types and the
// controller/datapath interface shared by the engine's modules.
// ----------------------------------------------------------------------------
package bfse_pkg;

  localparam int PROG_DEPTH = 4096;
  localparam int TAPE_DEPTH = 4096;
  localparam int PROG_AW    = $clog2(PROG_DEPTH);
  localparam int TAPE_AW    = $clog2(TAPE_DEPTH);
  localparam int IP_W       = PROG_AW + 1;
  localparam int NEST_W     = PROG_AW + 1;
  localparam int CLR_DEPTH  = (PROG_DEPTH > TAPE_DEPTH) ? PROG_DEPTH : TAPE_DEPTH;
  localparam int CLR_AW     = $clog2(CLR_DEPTH);
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPE_LEN = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [1:0] HALT_RUN     = 2'd0;
  localparam logic [1:0] HALT_END     = 2'd1;
  localparam logic [1:0] HALT_QUIT    = 2'd2;
  localparam logic [1:0] HALT_BRACKET = 2'd3;

  localparam logic [7:0] SYM_NONE  = 8'h00;
  localparam logic [7:0] SYM_LEFT  = 8'h3C;
  localparam logic [7:0] SYM_RIGHT = 8'h3E;
  localparam logic [7:0] SYM_INC   = 8'h2B;
  localparam logic [7:0] SYM_DEC   = 8'h2D;
  localparam logic [7:0] SYM_OUT   = 8'h2E;
  localparam logic [7:0] SYM_IN    = 8'h2C;
  localparam logic [7:0] SYM_OPEN  = 8'h5B;
  localparam logic [7:0] SYM_CLOSE = 8'h5D;
  localparam logic [7:0] SYM_QUIT  = 8'h40;
  localparam logic [7:0] SYM_OUTD  = 8'h21;
  localparam logic [7:0] SYM_IND   = 8'h3F;

  typedef struct packed {
    logic       op;
    logic [11:0] prog_addr;
    logic [7:0] prog_byte;
    logic [7:0] in_byte;
  } cmd_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_decimal;
    logic       in_used;
    logic [1:0] run_status;
    logic [7:0] cell_value;
  } res_t;

  typedef struct packed {
    logic clr_en;
    logic accept;
    logic exec;
    logic cap;
    logic scan_f;
    logic scan_b;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic pend_full;
    logic pend_drain;
    logic go_cap;
    logic go_fwd;
    logic go_bwd;
    logic scan_done;
  } stat_t;

  function automatic logic [7:0] bfse_decode(input logic [7:0] raw, input logic rev);
    logic [7:0] s;
    s = raw;
    if (rev) begin
      case (raw)
        SYM_LEFT:  s = SYM_RIGHT;
        SYM_RIGHT: s = SYM_LEFT;
        SYM_INC:   s = SYM_DEC;
        SYM_DEC:   s = SYM_INC;
        SYM_OPEN:  s = SYM_CLOSE;
        SYM_CLOSE: s = SYM_OPEN;
        SYM_OUT:   s = SYM_IN;
        SYM_IN:    s = SYM_OUT;
        SYM_OUTD:  s = SYM_IND;
        SYM_IND:   s = SYM_OUTD;
        default:   s = raw;
      endcase
    end
    return s;
  endfunction

endpackage

>>> hw/rtl/brainfuck_step_engine_core.sv
// ----------------------------------------------------------------------------
// Brainfuck step engine
// Runs a byte-coded program held in a 4096-byte program memory against a
// 4096-cell byte tape, one instruction per step item.
//
// The cmd channel carries one item per transfer: a load writes a program
// byte (a load at address zero also restarts the program), a step runs the
// instruction at the instruction pointer. Every item gives exactly one
// result on the res channel. Configuration (reverse mode, tape length) is
// written through cfg_we, cfg_idx and cfg_data; the user must write it only
// while the engine is idle, as the block itself does not enforce this. An
// item is executed once taken; a pointer move, and a load at address zero that
// moves the pointer, add a capture step, since the new cell is read back from
// tape memory. A taken bracket adds a scan, which reads program memory one
// byte a cycle. After reset both memories are cleared in a sweep with
// cmd_stall held high. Results wait in a staging register and an output
// register, so one item can be taken while a result is stalled; with both
// full, cmd_stall stays high until res_stall drops.
// ----------------------------------------------------------------------------
module brainfuck_step_engine_core import bfse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  cmd_t                 cmd,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_t                 res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);

  ctl_t  ctl;
  stat_t stat;

  bfse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  bfse_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

>>> hw/rtl/bfse_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/bfse_ctrl.sv
// ----------------------------------------------------------------------------
// Brainfuck step engine controller
// Sequences memory clearing, item acceptance, instruction execution, cell
// read-back and bracket scans, and tells the datapath when a result is done.
// ----------------------------------------------------------------------------
`include "brainfuck_step_engine_core_defines.svh"

module bfse_ctrl import bfse_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  output logic  cmd_stall,
  input  stat_t stat,
  output ctl_t  ctl
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_EXEC   = 6'b000100,
    ST_CAP    = 6'b001000,
    ST_SCAN_F = 6'b010000,
    ST_SCAN_B = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign cmd_stall = (state != ST_IDLE) || (stat.pend_full && !stat.pend_drain);

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      ST_CLEAR: begin
        ctl.clr_en = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid && !cmd_stall) begin
          ctl.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.exec = 1'b1;
        if (stat.go_cap) begin
          state_next = ST_CAP;
        end else if (stat.go_fwd) begin
          state_next = ST_SCAN_F;
        end else if (stat.go_bwd) begin
          state_next = ST_SCAN_B;
        end else begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_CAP: begin
        ctl.cap    = 1'b1;
        ctl.finish = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SCAN_F: begin
        ctl.scan_f = 1'b1;
        if (stat.scan_done) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN_B: begin
        ctl.scan_b = 1'b1;
        if (stat.scan_done) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  `BFSE_ASSERT_IMP(a_finish_empty, ctl.finish, !stat.pend_full, "Result finished while staging is full.")
  `BFSE_ASSERT_NEXT(a_accept_exec, ctl.accept, state == ST_EXEC, "Accepted item did not execute.")
  `BFSE_ASSERT_IMP(a_scan_entry, state == ST_SCAN_F && $past(state) != ST_SCAN_F, $past(state) == ST_EXEC && $past(stat.go_fwd), "Forward scan entered without a taken bracket.")

endmodule

>>> hw/rtl/bfse_dpath.sv
// ----------------------------------------------------------------------------
// Brainfuck step engine datapath
// Program and tape memories, pointers, status, configuration registers,
// instruction decode, bracket scan unit and the result staging and output
// registers.
// ----------------------------------------------------------------------------
module bfse_dpath import bfse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_t                 ctl,
  output stat_t                stat,
  input  cmd_t                 cmd,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_t                 res
);

  logic               rev;
  logic [TAPE_AW-1:0] lim;
  logic [TAPE_AW-1:0] lim_cfg;
  logic [IP_W-1:0]    ip;
  logic [TAPE_AW-1:0] cp;
  logic [1:0]         halt;
  cmd_t               q;
  logic [PROG_AW-1:0] sa;
  logic [NEST_W-1:0]  nest;
  res_t               pend;
  logic               pend_full;
  logic [CLR_AW-1:0]  clr_addr;

  logic [IP_W-1:0]    ip_next;
  logic [TAPE_AW-1:0] cp_next;
  logic [1:0]         halt_next;
  logic [PROG_AW-1:0] sa_next;
  logic [NEST_W-1:0]  nest_next;

  logic [TAPE_AW-1:0] cp_clamp;
  logic [IP_W-1:0]    ip_inc;
  logic               ip_end;
  logic [PROG_AW-1:0] sa_step;
  logic [7:0]         raw;
  logic [7:0]         sym;
  logic [7:0]         sd;
  logic [7:0]         v;
  logic [7:0]         wval;
  logic [7:0]         cell_new;
  logic               t_wr;
  logic               p_ld;
  logic               ov;
  logic               od;
  logic               iu;
  logic [7:0]         ob;
  logic               go_fwd;
  logic               go_bwd;
  logic               scan_done;
  logic               pend_drain;

  logic               p_we;
  logic [PROG_AW-1:0] p_waddr;
  logic [7:0]         p_wdata;
  logic [PROG_AW-1:0] p_raddr;
  logic [7:0]         p_rdata;
  logic               t_we;
  logic [TAPE_AW-1:0] t_waddr;
  logic [7:0]         t_wdata;
  logic [TAPE_AW-1:0] t_raddr;
  logic [7:0]         t_rdata;

  bfse_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  bfse_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  always_comb begin
    if (cfg_data == '0) begin
      lim_cfg = '0;
    end else if (cfg_data > CFG_W'(TAPE_DEPTH)) begin
      lim_cfg = TAPE_AW'(TAPE_DEPTH - 1);
    end else begin
      lim_cfg = TAPE_AW'(cfg_data - CFG_W'(1));
    end
  end

  always_comb begin
    cp_clamp  = (cp > lim) ? lim : cp;
    ip_inc    = ip + IP_W'(1);
    ip_end    = (ip == IP_W'(PROG_DEPTH));
    raw       = ip_end ? SYM_NONE : p_rdata;
    sym       = bfse_decode(raw, rev);
    sd        = bfse_decode(p_rdata, rev);
    v         = t_rdata;
    sa_step   = ctl.scan_b ? (sa - PROG_AW'(1)) : (sa + PROG_AW'(1));

    ip_next   = ip;
    cp_next   = cp;
    halt_next = halt;
    sa_next   = sa;
    nest_next = nest;
    wval      = v;
    t_wr      = 1'b0;
    p_ld      = 1'b0;
    ov        = 1'b0;
    ob        = 8'h00;
    od        = 1'b0;
    iu        = 1'b0;
    go_fwd    = 1'b0;
    go_bwd    = 1'b0;
    scan_done = 1'b0;

    if (ctl.exec) begin
      if (q.op == OP_LOAD) begin
        p_ld = (IP_W'(q.prog_addr) < IP_W'(PROG_DEPTH));
        if (q.prog_addr == '0) begin
          ip_next   = '0;
          cp_next   = '0;
          halt_next = HALT_RUN;
        end
      end else if (halt != HALT_RUN) begin
        halt_next = halt;
      end else if (raw == SYM_NONE) begin
        halt_next = HALT_END;
      end else begin
        ip_next = ip_inc;
        case (sym)
          SYM_LEFT: begin
            if (cp != '0) begin
              cp_next = cp - TAPE_AW'(1);
            end
          end
          SYM_RIGHT: begin
            if (cp < lim) begin
              cp_next = cp + TAPE_AW'(1);
            end
          end
          SYM_INC: begin
            t_wr = 1'b1;
            wval = v + 8'd1;
          end
          SYM_DEC: begin
            t_wr = 1'b1;
            wval = v - 8'd1;
          end
          SYM_OUT: begin
            ov = 1'b1;
            ob = v;
          end
          SYM_OUTD: begin
            ov = 1'b1;
            ob = v;
            od = 1'b1;
          end
          SYM_IN, SYM_IND: begin
            t_wr = 1'b1;
            wval = q.in_byte;
            iu   = 1'b1;
          end
          SYM_QUIT: begin
            halt_next = HALT_QUIT;
            ip_next   = ip;
          end
          SYM_OPEN: begin
            if (v == 8'h00) begin
              ip_next = ip;
              if (ip_inc == IP_W'(PROG_DEPTH)) begin
                halt_next = HALT_BRACKET;
              end else begin
                go_fwd    = 1'b1;
                sa_next   = ip_inc[PROG_AW-1:0];
                nest_next = NEST_W'(1);
              end
            end
          end
          SYM_CLOSE: begin
            if (v != 8'h00) begin
              ip_next = ip;
              if (ip == '0) begin
                halt_next = HALT_BRACKET;
              end else begin
                go_bwd    = 1'b1;
                sa_next   = ip[PROG_AW-1:0] - PROG_AW'(1);
                nest_next = NEST_W'(1);
              end
            end
          end
          default: begin
            ip_next = ip_inc;
          end
        endcase
      end
    end

    if (ctl.scan_f) begin
      if (p_rdata == SYM_NONE) begin
        scan_done = 1'b1;
        halt_next = HALT_BRACKET;
      end else if (sd == SYM_CLOSE && nest == NEST_W'(1)) begin
        scan_done = 1'b1;
        ip_next   = IP_W'(sa);
      end else begin
        if (sd == SYM_OPEN) begin
          nest_next = nest + NEST_W'(1);
        end else if (sd == SYM_CLOSE) begin
          nest_next = nest - NEST_W'(1);
        end
        if (sa == PROG_AW'(PROG_DEPTH - 1)) begin
          scan_done = 1'b1;
          halt_next = HALT_BRACKET;
        end else begin
          sa_next = sa_step;
        end
      end
    end

    if (ctl.scan_b) begin
      if (sd == SYM_OPEN && nest == NEST_W'(1)) begin
        scan_done = 1'b1;
        ip_next   = IP_W'(sa);
      end else begin
        if (sd == SYM_CLOSE) begin
          nest_next = nest + NEST_W'(1);
        end else if (sd == SYM_OPEN) begin
          nest_next = nest - NEST_W'(1);
        end
        if (sa == '0) begin
          scan_done = 1'b1;
          halt_next = HALT_BRACKET;
        end else begin
          sa_next = sa_step;
        end
      end
    end
  end

  assign cell_new   = t_wr ? wval : v;
  assign pend_drain = pend_full && (!res_valid || !res_stall);

  assign p_we    = ctl.clr_en ? ({1'b0, clr_addr} < (CLR_AW+1)'(PROG_DEPTH)) : p_ld;
  assign p_waddr = ctl.clr_en ? clr_addr[PROG_AW-1:0] : q.prog_addr[PROG_AW-1:0];
  assign p_wdata = ctl.clr_en ? 8'h00 : q.prog_byte;
  assign p_raddr = ctl.accept ? ip[PROG_AW-1:0] : (ctl.exec ? sa_next : sa_step);

  assign t_we    = ctl.clr_en ? ({1'b0, clr_addr} < (CLR_AW+1)'(TAPE_DEPTH)) : t_wr;
  assign t_waddr = ctl.clr_en ? clr_addr[TAPE_AW-1:0] : cp;
  assign t_wdata = ctl.clr_en ? 8'h00 : wval;
  assign t_raddr = ctl.accept ? cp_clamp : cp_next;

  always_comb begin
    stat            = '0;
    stat.clr_last   = (clr_addr == CLR_AW'(CLR_DEPTH - 1));
    stat.pend_full  = pend_full;
    stat.pend_drain = pend_drain;
    stat.go_cap     = ctl.exec && (cp_next != cp);
    stat.go_fwd     = go_fwd;
    stat.go_bwd     = go_bwd;
    stat.scan_done  = scan_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rev       <= 1'b0;
      lim       <= TAPE_AW'(TAPE_DEPTH - 1);
      ip        <= '0;
      cp        <= '0;
      halt      <= HALT_RUN;
      pend_full <= 1'b0;
      res_valid <= 1'b0;
      clr_addr  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_REVERSE:  rev <= cfg_data[0];
          CFG_TAPE_LEN: lim <= lim_cfg;
          default:      rev <= rev;
        endcase
      end
      if (ctl.clr_en) begin
        clr_addr <= clr_addr + CLR_AW'(1);
      end
      cp   <= ctl.accept ? cp_clamp : cp_next;
      ip   <= ip_next;
      halt <= halt_next;
      if (ctl.finish) begin
        pend_full <= 1'b1;
      end else if (pend_drain) begin
        pend_full <= 1'b0;
      end
      if (pend_drain) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      q <= cmd;
    end
    sa   <= sa_next;
    nest <= nest_next;
    if (ctl.exec) begin
      pend.out_valid   <= ov;
      pend.out_byte    <= ob;
      pend.out_decimal <= od;
      pend.in_used     <= iu;
      pend.cell_value  <= cell_new;
    end
    if (ctl.cap) begin
      pend.cell_value <= t_rdata;
    end
    if (!pend_full) begin
      pend.run_status <= halt_next;
    end
    if (pend_drain) begin
      res <= pend;
    end
  end

endmodule
